// ----- rtl/circular_list_with_value_delete_unit_macros.svh -----
// Assertion macros for the circular list unit checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef CIRCULAR_LIST_WITH_VALUE_DELETE_UNIT_MACROS_SVH
`define CIRCULAR_LIST_WITH_VALUE_DELETE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CLDU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CLDU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cldu_pkg.sv -----
// Shared types and codes for the circular list unit.
// Used by the controller, the datapath, the top level and the checker.
package cldu_pkg;

    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 5;

    typedef logic [2:0] command_t;
    typedef logic [1:0] status_t;
    typedef logic [4:0] op_t;

    localparam command_t CMD_INS_HEAD = 3'd0;
    localparam command_t CMD_INS_TAIL = 3'd1;
    localparam command_t CMD_DEL_VAL  = 3'd2;
    localparam command_t CMD_DEL_HEAD = 3'd3;
    localparam command_t CMD_DEL_TAIL = 3'd4;
    localparam command_t CMD_QUERY    = 3'd5;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_EMPTY     = 2'd1;
    localparam status_t STATUS_NOT_FOUND = 2'd2;
    localparam status_t STATUS_FULL      = 2'd3;

    // Datapath micro-operations
    localparam op_t OP_NOP        = 5'd0;
    localparam op_t OP_LOAD       = 5'd1;
    localparam op_t OP_TAKE_FRESH = 5'd2;
    localparam op_t OP_POP_RD     = 5'd3;
    localparam op_t OP_POP        = 5'd4;
    localparam op_t OP_INS_LINK   = 5'd5;
    localparam op_t OP_INS_HEAD   = 5'd6;
    localparam op_t OP_INS_TAIL   = 5'd7;
    localparam op_t OP_CLEAR      = 5'd8;
    localparam op_t OP_DH_UNLINK  = 5'd9;
    localparam op_t OP_HVAL       = 5'd10;
    localparam op_t OP_TVAL       = 5'd11;
    localparam op_t OP_DT_STEP    = 5'd12;
    localparam op_t OP_DT_UNLINK  = 5'd13;
    localparam op_t OP_DV_STEP    = 5'd14;
    localparam op_t OP_DV_UNLINK  = 5'd15;
    localparam op_t OP_OUT        = 5'd16;

    typedef struct packed {
        op_t     op;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic count_full;
        logic free_empty;
        logic link_is_tail;
        logic match;
        logic walk_last;
        logic cur_is_head;
    } dp_stat_t;

endpackage

// ----- rtl/cldu_ctrl.sv -----
// Controller state machine of the circular list unit.
// Depends on cldu_pkg; drives the datapath through dp_cmd_t.
module cldu_ctrl
    import cldu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  command_t command,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  dp_cmd,
    input  dp_stat_t dp_stat
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ALLOC = 4'd1;
    localparam logic [3:0] S_POP   = 4'd2;
    localparam logic [3:0] S_LINK  = 4'd3;
    localparam logic [3:0] S_INS   = 4'd4;
    localparam logic [3:0] S_DH    = 4'd5;
    localparam logic [3:0] S_HVAL  = 4'd6;
    localparam logic [3:0] S_TVAL  = 4'd7;
    localparam logic [3:0] S_DT    = 4'd8;
    localparam logic [3:0] S_DV    = 4'd9;
    localparam logic [3:0] S_CLEAR = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] state_reg, state_next;
    status_t    result_st_reg, result_st_next;
    logic       at_head_reg, at_head_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        result_st_next = result_st_reg;
        at_head_next   = at_head_reg;
        dp_cmd.op      = OP_NOP;
        dp_cmd.status  = result_st_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.op      = OP_LOAD;
                    result_st_next = STATUS_OK;
                    at_head_next   = (command == CMD_INS_HEAD);
                    unique case (command)
                        CMD_INS_HEAD, CMD_INS_TAIL:
                        begin
                            if (dp_stat.count_full)
                            begin
                                result_st_next = STATUS_FULL;
                                state_next     = S_DONE;
                            end
                            else
                            begin
                                state_next = S_ALLOC;
                            end
                        end
                        CMD_DEL_VAL:
                        begin
                            if (dp_stat.count_zero)
                            begin
                                result_st_next = STATUS_EMPTY;
                                state_next     = S_DONE;
                            end
                            else
                            begin
                                state_next = S_DV;
                            end
                        end
                        CMD_DEL_HEAD, CMD_DEL_TAIL:
                        begin
                            if (dp_stat.count_zero)
                            begin
                                result_st_next = STATUS_EMPTY;
                                state_next     = S_DONE;
                            end
                            else if (dp_stat.count_one)
                            begin
                                state_next = S_CLEAR;
                            end
                            else if (command == CMD_DEL_HEAD)
                            begin
                                state_next = S_DH;
                            end
                            else
                            begin
                                state_next = S_DT;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (dp_stat.free_empty)
                begin
                    dp_cmd.op  = OP_TAKE_FRESH;
                    state_next = dp_stat.count_zero ? S_INS : S_LINK;
                end
                else
                begin
                    dp_cmd.op  = OP_POP_RD;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                dp_cmd.op  = OP_POP;
                state_next = dp_stat.count_zero ? S_INS : S_LINK;
            end
            S_LINK:
            begin
                dp_cmd.op  = OP_INS_LINK;
                state_next = S_INS;
            end
            S_INS:
            begin
                dp_cmd.op  = at_head_reg ? OP_INS_HEAD : OP_INS_TAIL;
                state_next = S_DONE;
            end
            S_DH:
            begin
                dp_cmd.op  = OP_DH_UNLINK;
                state_next = S_HVAL;
            end
            S_HVAL:
            begin
                dp_cmd.op  = OP_HVAL;
                state_next = S_DONE;
            end
            S_TVAL:
            begin
                dp_cmd.op  = OP_TVAL;
                state_next = S_DONE;
            end
            S_DT:
            begin
                // walk until the link points at the tail
                if (dp_stat.link_is_tail)
                begin
                    dp_cmd.op  = OP_DT_UNLINK;
                    state_next = S_TVAL;
                end
                else
                begin
                    dp_cmd.op = OP_DT_STEP;
                end
            end
            S_DV:
            begin
                if (dp_stat.match)
                begin
                    if (dp_stat.count_one)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        dp_cmd.op  = OP_DV_UNLINK;
                        state_next = dp_stat.cur_is_head ? S_HVAL : S_DONE;
                    end
                end
                else if (dp_stat.walk_last)
                begin
                    result_st_next = STATUS_NOT_FOUND;
                    state_next     = S_DONE;
                end
                else
                begin
                    dp_cmd.op = OP_DV_STEP;
                end
            end
            S_CLEAR:
            begin
                dp_cmd.op  = OP_CLEAR;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.op  = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (dp_cmd.op == OP_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            result_st_reg <= STATUS_OK;
            at_head_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            result_st_reg <= result_st_next;
            at_head_reg   <= at_head_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/cldu_dpath.sv -----
// Datapath of the circular list unit: value, link and free-slot memories,
// head/tail/count registers, walk registers and the result register.
// Depends on cldu_pkg; executes the micro-operations of cldu_ctrl.
module cldu_dpath
    import cldu_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  dp_cmd_t                         dp_cmd,
    output dp_stat_t                        dp_stat,
    input  logic signed [VALUE_W-1:0]       item_value,
    output status_t                         status,
    output logic signed [VALUE_W-1:0]       head_value,
    output logic signed [VALUE_W-1:0]       tail_value,
    output logic [ENTRY_COUNT_W-1:0]        entry_count,
    output logic                            is_empty
);

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // memories
    logic signed [VALUE_W-1:0] value_mem [DEPTH];
    logic [SW-1:0]             link_mem  [DEPTH];
    logic [SW-1:0]             free_mem  [DEPTH];

    logic signed [VALUE_W-1:0] value_rd_reg;
    logic [SW-1:0]             link_rd_reg;
    logic [SW-1:0]             free_rd_reg;

    logic                      value_we, link_we, free_we;
    logic [SW-1:0]             value_waddr, link_waddr, free_waddr;
    logic signed [VALUE_W-1:0] value_wdata;
    logic [SW-1:0]             link_wdata, free_wdata;
    logic [SW-1:0]             value_raddr, link_raddr, free_raddr;

    // list state
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] fsp_reg, fsp_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic [CW-1:0] fsp_dec;

    // payload
    logic signed [VALUE_W-1:0] hval_reg, hval_next;
    logic signed [VALUE_W-1:0] tval_reg, tval_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic signed [VALUE_W-1:0] pval_reg, pval_next;
    logic [SW-1:0]             cur_reg, cur_next;
    logic [SW-1:0]             prev_reg, prev_next;
    logic [SW-1:0]             k_reg, k_next;
    logic [SW-1:0]             slot_reg, slot_next;

    status_t                    out_status_reg, out_status_next;
    logic signed [VALUE_W-1:0]  out_head_reg, out_head_next;
    logic signed [VALUE_W-1:0]  out_tail_reg, out_tail_next;
    logic [ENTRY_COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                       out_empty_reg, out_empty_next;

    logic count_zero;

    assign count_zero = (count_reg == '0);
    assign fsp_dec    = fsp_reg - CW'(1);

    assign dp_stat.count_zero   = count_zero;
    assign dp_stat.count_one    = (count_reg == CW'(1));
    assign dp_stat.count_full   = (count_reg == CW'(DEPTH));
    assign dp_stat.free_empty   = (fsp_reg == '0);
    assign dp_stat.link_is_tail = (link_rd_reg == tail_reg);
    assign dp_stat.match        = (value_rd_reg == val_reg);
    assign dp_stat.walk_last    = ((CW'(k_reg) + CW'(1)) == count_reg);
    assign dp_stat.cur_is_head  = (cur_reg == head_reg);

    assign status      = out_status_reg;
    assign head_value  = out_head_reg;
    assign tail_value  = out_tail_reg;
    assign entry_count = out_count_reg;
    assign is_empty    = out_empty_reg;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        fsp_next    = fsp_reg;
        fresh_next  = fresh_reg;
        hval_next   = hval_reg;
        tval_next   = tval_reg;
        val_next    = val_reg;
        pval_next   = pval_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        k_next      = k_reg;
        slot_next   = slot_reg;

        out_status_next = out_status_reg;
        out_head_next   = out_head_reg;
        out_tail_next   = out_tail_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;

        value_we    = 1'b0;
        value_waddr = slot_reg;
        value_wdata = val_reg;
        link_we     = 1'b0;
        link_waddr  = tail_reg;
        link_wdata  = slot_reg;
        free_we     = 1'b0;
        free_waddr  = fsp_reg[SW-1:0];
        free_wdata  = head_reg;
        value_raddr = head_reg;
        link_raddr  = head_reg;
        free_raddr  = fsp_dec[SW-1:0];

        unique case (dp_cmd.op)
            OP_LOAD:
            begin
                // reads at the head slot are issued here for the walks
                val_next  = item_value;
                cur_next  = head_reg;
                prev_next = tail_reg;
                k_next    = '0;
            end
            OP_TAKE_FRESH:
            begin
                slot_next  = fresh_reg[SW-1:0];
                fresh_next = fresh_reg + CW'(1);
            end
            OP_POP_RD:
            begin
                fsp_next = fsp_dec;
            end
            OP_POP:
            begin
                slot_next = free_rd_reg;
            end
            OP_INS_LINK:
            begin
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = slot_reg;
            end
            OP_INS_HEAD, OP_INS_TAIL:
            begin
                value_we    = 1'b1;
                value_waddr = slot_reg;
                value_wdata = val_reg;
                link_we     = 1'b1;
                link_waddr  = slot_reg;
                link_wdata  = count_zero ? slot_reg : head_reg;
                count_next  = count_reg + CW'(1);
                if (count_zero)
                begin
                    head_next = slot_reg;
                    tail_next = slot_reg;
                    hval_next = val_reg;
                    tval_next = val_reg;
                end
                else if (dp_cmd.op == OP_INS_HEAD)
                begin
                    head_next = slot_reg;
                    hval_next = val_reg;
                end
                else
                begin
                    tail_next = slot_reg;
                    tval_next = val_reg;
                end
            end
            OP_CLEAR:
            begin
                free_we    = 1'b1;
                free_wdata = head_reg;
                fsp_next   = fsp_reg + CW'(1);
                count_next = '0;
                head_next  = '0;
                tail_next  = '0;
            end
            OP_DH_UNLINK:
            begin
                head_next   = link_rd_reg;
                link_we     = 1'b1;
                link_waddr  = tail_reg;
                link_wdata  = link_rd_reg;
                free_we     = 1'b1;
                free_wdata  = head_reg;
                fsp_next    = fsp_reg + CW'(1);
                count_next  = count_reg - CW'(1);
                value_raddr = link_rd_reg;
            end
            OP_HVAL:
            begin
                hval_next = value_rd_reg;
            end
            OP_TVAL:
            begin
                tval_next = value_rd_reg;
            end
            OP_DT_STEP:
            begin
                cur_next   = link_rd_reg;
                link_raddr = link_rd_reg;
            end
            OP_DT_UNLINK:
            begin
                link_we     = 1'b1;
                link_waddr  = cur_reg;
                link_wdata  = head_reg;
                tail_next   = cur_reg;
                free_we     = 1'b1;
                free_wdata  = tail_reg;
                fsp_next    = fsp_reg + CW'(1);
                count_next  = count_reg - CW'(1);
                value_raddr = cur_reg;
            end
            OP_DV_STEP:
            begin
                prev_next   = cur_reg;
                pval_next   = value_rd_reg;
                cur_next    = link_rd_reg;
                k_next      = k_reg + SW'(1);
                value_raddr = link_rd_reg;
                link_raddr  = link_rd_reg;
            end
            OP_DV_UNLINK:
            begin
                link_we     = 1'b1;
                link_waddr  = prev_reg;
                link_wdata  = link_rd_reg;
                free_we     = 1'b1;
                free_wdata  = cur_reg;
                fsp_next    = fsp_reg + CW'(1);
                count_next  = count_reg - CW'(1);
                value_raddr = link_rd_reg;
                if (cur_reg == head_reg)
                begin
                    head_next = link_rd_reg;
                end
                // the entry before the tail was visited, so its value is at hand
                if (cur_reg == tail_reg)
                begin
                    tail_next = prev_reg;
                    tval_next = pval_reg;
                end
            end
            OP_OUT:
            begin
                out_status_next = dp_cmd.status;
                out_head_next   = count_zero ? '0 : hval_reg;
                out_tail_next   = count_zero ? '0 : tval_reg;
                out_count_next  = ENTRY_COUNT_W'(count_reg);
                out_empty_next  = count_zero;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[value_waddr] <= value_wdata;
        end
        value_rd_reg <= value_mem[value_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rd_reg <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[free_waddr] <= free_wdata;
        end
        free_rd_reg <= free_mem[free_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fsp_reg   <= '0;
            fresh_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fsp_reg   <= fsp_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hval_reg       <= hval_next;
        tval_reg       <= tval_next;
        val_reg        <= val_next;
        pval_reg       <= pval_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        k_reg          <= k_next;
        slot_reg       <= slot_next;
        out_status_reg <= out_status_next;
        out_head_reg   <= out_head_next;
        out_tail_reg   <= out_tail_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
    end

endmodule

// ----- rtl/circular_list_with_value_delete_unit.sv -----
// Circular list unit: one request at a time, one result per request.
// The walk over the link memory, one link per cycle, makes delete tail and delete value the
// longest requests. No new request is taken until the result register of the last one is
// loaded, and a stalled result that still waits holds the unit in its done state longer.
// Reset is asynchronous, active low: the list comes up empty; no memory clearing pass.
module circular_list_with_value_delete_unit
    import cldu_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                command,
    input  logic signed [31:0]        item_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                status,
    output logic signed [31:0]        head_value,
    output logic signed [31:0]        tail_value,
    output logic [4:0]                entry_count,
    output logic                      is_empty
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    cldu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    cldu_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .dp_stat     (dp_stat),
        .item_value  (item_value),
        .status      (status),
        .head_value  (head_value),
        .tail_value  (tail_value),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

endmodule

// ----- rtl/cldu_checker.sv -----
// Port-level checker for the circular list unit, bound to the top level.
// Depends on cldu_pkg and the assertion macros header.
`include "circular_list_with_value_delete_unit_macros.svh"

module cldu_checker
    import cldu_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic signed [31:0] head_value,
    input logic signed [31:0] tail_value,
    input logic [4:0]         entry_count,
    input logic               is_empty
);

    // an empty list shows zero count and zero head and tail values
    `CLDU_ASSERT_NOW(a_empty_zero, out_valid && is_empty,
        (entry_count == 5'd0) && (head_value == 32'sd0) && (tail_value == 32'sd0),
        "empty result with nonzero fields")

    // a refused delete on an empty list leaves the list empty
    `CLDU_ASSERT_NOW(a_empty_status, out_valid && (status == STATUS_EMPTY), is_empty,
        "empty status on a nonempty list")

    // a full list can never be empty
    `CLDU_ASSERT_NOW(a_full_status, out_valid && (status == STATUS_FULL), !is_empty,
        "full status on an empty list")

    // a stalled result holds
    `CLDU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(head_value) && $stable(tail_value)
        && $stable(entry_count) && $stable(is_empty),
        "stalled result changed")

    // one request at a time: drop ready right after an accepted request
    `CLDU_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready,
        "request accepted while busy")

endmodule

bind circular_list_with_value_delete_unit cldu_checker u_cldu_checker (.*);
